/* hw/rtl/cau_pkg.sv */
// Shared types, codes and defaults for the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int PORT_W         = 32;

   localparam logic [2:0] FUNC_ADD  = 3'd0;
   localparam logic [2:0] FUNC_SUB  = 3'd1;
   localparam logic [2:0] FUNC_MUL  = 3'd2;
   localparam logic [2:0] FUNC_DIV  = 3'd3;
   localparam logic [2:0] FUNC_CONJ = 3'd4;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DZ  = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic [2:0]               func;
      logic signed [PORT_W-1:0] a_re;
      logic signed [PORT_W-1:0] a_im;
      logic signed [PORT_W-1:0] b_re;
      logic signed [PORT_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [PORT_W-1:0] res_re;
      logic signed [PORT_W-1:0] res_im;
      logic [1:0]               status;
   } rsp_type;

endpackage

/* hw/rtl/complex_arithmetic_unit_core.sv */
// Pipelined complex ALU: add, subtract, multiply, divide and conjugate in signed fixed point.
// One item enters per cycle unless the output buffer is full. Each result passes through
// four operand, product, sum and magnitude stages, a dividend and rounding stage and the
// restoring divider, which resolves one quotient bit per pipeline stage, and then enters a
// two-entry output buffer. The buffer lets new items in while a finished result waits to be
// taken; the pipeline holds only when both entries are full.
module complex_arithmetic_unit_core #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 1;
   localparam int NW   = PW + FRAC_BITS + 2;
   localparam int D2W  = PW + 1;
   localparam int QB   = DW;
   localparam int NSTG = QB + 1;
   localparam int VW   = PW + 3;
   localparam longint MAXL = (longint'(1) <<< (DW - 1)) - 1;
   localparam logic signed [VW-1:0] MAXV = VW'(MAXL);
   localparam logic signed [VW-1:0] MINV = VW'(-MAXL - 1);
   localparam logic [SW:0] HALF = ((SW + 1)'(1) << FRAC_BITS) >> 1;
   localparam logic signed [DW-1:0] MAXD = {1'b0, {(DW - 1){1'b1}}};
   localparam logic signed [DW-1:0] MIND = {1'b1, {(DW - 1){1'b0}}};

   typedef struct packed {
      logic [2:0]           func;
      logic                 dz;
      logic                 neg_re;
      logic                 neg_im;
      logic [D2W-1:0]       d2;
      logic [NW-1:0]        r_re;
      logic [NW-1:0]        r_im;
      logic [QB-1:0]        q_re;
      logic [QB-1:0]        q_im;
      logic                 ov_re;
      logic                 ov_im;
      logic signed [VW-1:0] fv_re;
      logic signed [VW-1:0] fv_im;
      logic                 fsat;
   } dstg_type;

   function automatic logic [NW:0] div_step(input logic [NW-1:0] r,
                                            input logic [D2W-1:0] d2, input int sh);
      logic [NW:0]   hi;
      logic [NW:0]   dx;
      logic [NW:0]   diff;
      logic [NW-1:0] lo_mask;
      logic          ge;
      logic [NW-1:0] rn;
      hi      = (NW + 1)'(r >> sh);
      dx      = (NW + 1)'(d2);
      ge      = hi >= dx;
      diff    = hi - dx;
      lo_mask = ~({NW{1'b1}} << sh);
      rn      = ge ? (NW'(diff << sh) | (r & lo_mask)) : r;
      return {ge, rn};
   endfunction

   logic       ce;
   logic [1:0] cnt_ff;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   rsp_type    mem_ff [0:1];
   logic       push;
   logic       pop;
   rsp_type    fin;

   assign ce        = (cnt_ff != 2'd2);
   assign req_ready = ce;

   // operand stage
   logic                 s1_valid_ff;
   logic [2:0]           s1_func_ff;
   logic signed [DW-1:0] s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_func_ff <= req_data.func;
         s1_ar_ff   <= req_data.a_re[DW-1:0];
         s1_ai_ff   <= req_data.a_im[DW-1:0];
         s1_br_ff   <= req_data.b_re[DW-1:0];
         s1_bi_ff   <= req_data.b_im[DW-1:0];
      end
   end

   // product stage
   logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;
   logic signed [DW:0]   lin_re_in, lin_im_in;
   logic                 s2_valid_ff;
   logic [2:0]           s2_func_ff;
   logic signed [PW-1:0] s2_rr_ff, s2_ii_ff, s2_ri_ff, s2_ir_ff, s2_sqr_ff, s2_sqi_ff;
   logic signed [DW:0]   s2_lre_ff, s2_lim_ff;

   assign ar_x = {s1_ar_ff[DW-1], s1_ar_ff};
   assign ai_x = {s1_ai_ff[DW-1], s1_ai_ff};
   assign br_x = {s1_br_ff[DW-1], s1_br_ff};
   assign bi_x = {s1_bi_ff[DW-1], s1_bi_ff};

   always_comb begin
      lin_re_in = '0;
      lin_im_in = '0;
      unique case (s1_func_ff)
         FUNC_ADD: begin
            lin_re_in = ar_x + br_x;
            lin_im_in = ai_x + bi_x;
         end
         FUNC_SUB: begin
            lin_re_in = ar_x - br_x;
            lin_im_in = ai_x - bi_x;
         end
         FUNC_CONJ: begin
            lin_re_in = ar_x;
            lin_im_in = -ai_x;
         end
         default: begin
            lin_re_in = '0;
            lin_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_func_ff <= s1_func_ff;
         s2_rr_ff   <= PW'(s1_ar_ff) * PW'(s1_br_ff);
         s2_ii_ff   <= PW'(s1_ai_ff) * PW'(s1_bi_ff);
         s2_ri_ff   <= PW'(s1_ar_ff) * PW'(s1_bi_ff);
         s2_ir_ff   <= PW'(s1_ai_ff) * PW'(s1_br_ff);
         s2_sqr_ff  <= PW'(s1_br_ff) * PW'(s1_br_ff);
         s2_sqi_ff  <= PW'(s1_bi_ff) * PW'(s1_bi_ff);
         s2_lre_ff  <= lin_re_in;
         s2_lim_ff  <= lin_im_in;
      end
   end

   // sum stage
   logic signed [SW-1:0] rr_x, ii_x, ri_x, ir_x;
   logic signed [SW-1:0] n_re_in, n_im_in;
   logic                 s3_valid_ff;
   logic [2:0]           s3_func_ff;
   logic signed [SW-1:0] s3_nre_ff, s3_nim_ff;
   logic [PW-1:0]        s3_d_ff;
   logic signed [DW:0]   s3_lre_ff, s3_lim_ff;

   assign rr_x = {s2_rr_ff[PW-1], s2_rr_ff};
   assign ii_x = {s2_ii_ff[PW-1], s2_ii_ff};
   assign ri_x = {s2_ri_ff[PW-1], s2_ri_ff};
   assign ir_x = {s2_ir_ff[PW-1], s2_ir_ff};

   always_comb begin
      n_re_in = '0;
      n_im_in = '0;
      unique case (s2_func_ff)
         FUNC_MUL: begin
            n_re_in = rr_x - ii_x;
            n_im_in = ri_x + ir_x;
         end
         FUNC_DIV: begin
            n_re_in = rr_x + ii_x;
            n_im_in = ir_x - ri_x;
         end
         default: begin
            n_re_in = '0;
            n_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ce) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_func_ff <= s2_func_ff;
         s3_nre_ff  <= n_re_in;
         s3_nim_ff  <= n_im_in;
         s3_d_ff    <= PW'(s2_sqr_ff + s2_sqi_ff);
         s3_lre_ff  <= s2_lre_ff;
         s3_lim_ff  <= s2_lim_ff;
      end
   end

   // magnitude stage
   logic                 s4_valid_ff;
   logic [2:0]           s4_func_ff;
   logic [SW-1:0]        s4_mre_ff, s4_mim_ff;
   logic                 s4_nre_ff, s4_nim_ff;
   logic [PW-1:0]        s4_d_ff;
   logic signed [DW:0]   s4_lre_ff, s4_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (ce) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s4_func_ff <= s3_func_ff;
         s4_mre_ff  <= s3_nre_ff[SW-1] ? SW'(-s3_nre_ff) : SW'(s3_nre_ff);
         s4_mim_ff  <= s3_nim_ff[SW-1] ? SW'(-s3_nim_ff) : SW'(s3_nim_ff);
         s4_nre_ff  <= s3_nre_ff[SW-1];
         s4_nim_ff  <= s3_nim_ff[SW-1];
         s4_d_ff    <= s3_d_ff;
         s4_lre_ff  <= s3_lre_ff;
         s4_lim_ff  <= s3_lim_ff;
      end
   end

   // dividend and rounding stage, an overflow-check stage, then one quotient bit per stage
   logic     vld_ff [0:NSTG];
   dstg_type dv_ff  [0:NSTG];
   dstg_type dv_in;
   logic [SW:0] rnd_re, rnd_im;

   assign rnd_re = ((SW + 1)'(s4_mre_ff) + HALF) >> FRAC_BITS;
   assign rnd_im = ((SW + 1)'(s4_mim_ff) + HALF) >> FRAC_BITS;

   always_comb begin
      dv_in        = '0;
      dv_in.func   = s4_func_ff;
      dv_in.dz     = (s4_d_ff == '0);
      dv_in.neg_re = s4_nre_ff;
      dv_in.neg_im = s4_nim_ff;
      dv_in.d2     = {s4_d_ff, 1'b0};
      dv_in.fv_re  = VW'(s4_lre_ff);
      dv_in.fv_im  = VW'(s4_lim_ff);
      if (s4_func_ff == FUNC_DIV) begin
         dv_in.r_re = NW'({s4_mre_ff[PW-1:0], {(FRAC_BITS + 1){1'b0}}}) + NW'(s4_d_ff);
         dv_in.r_im = NW'({s4_mim_ff[PW-1:0], {(FRAC_BITS + 1){1'b0}}}) + NW'(s4_d_ff);
      end else begin
         dv_in.r_re = NW'(rnd_re);
         dv_in.r_im = NW'(rnd_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (ce) begin
         vld_ff[0] <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dv_ff[0] <= dv_in;
      end
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_div
      localparam int QI = (k == 0) ? 0 : QB - k;
      dstg_type             nxt;
      logic [NW:0]          st_re, st_im;
      logic signed [VW-1:0] x_re, x_im;

      assign st_re = div_step(dv_ff[k].r_re, dv_ff[k].d2, QB - k);
      assign st_im = div_step(dv_ff[k].r_im, dv_ff[k].d2, QB - k);
      assign x_re  = $signed({1'b0, dv_ff[k].r_re[PW+1:0]});
      assign x_im  = $signed({1'b0, dv_ff[k].r_im[PW+1:0]});

      always_comb begin
         nxt = dv_ff[k];
         if (k == 0) begin
            nxt.ov_re = st_re[NW];
            nxt.ov_im = st_im[NW];
            if (dv_ff[k].func == FUNC_MUL) begin
               nxt.fv_re = dv_ff[k].neg_re ? -x_re : x_re;
               nxt.fv_im = dv_ff[k].neg_im ? -x_im : x_im;
            end
         end else begin
            nxt.r_re     = st_re[NW-1:0];
            nxt.r_im     = st_im[NW-1:0];
            nxt.q_re[QI] = st_re[NW];
            nxt.q_im[QI] = st_im[NW];
         end
         if (k == 1) begin
            nxt.fsat = (dv_ff[k].fv_re > MAXV) || (dv_ff[k].fv_re < MINV) ||
                       (dv_ff[k].fv_im > MAXV) || (dv_ff[k].fv_im < MINV);
            if (dv_ff[k].fv_re > MAXV) begin
               nxt.fv_re = MAXV;
            end else if (dv_ff[k].fv_re < MINV) begin
               nxt.fv_re = MINV;
            end
            if (dv_ff[k].fv_im > MAXV) begin
               nxt.fv_im = MAXV;
            end else if (dv_ff[k].fv_im < MINV) begin
               nxt.fv_im = MINV;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k + 1] <= 1'b0;
         end else if (ce) begin
            vld_ff[k + 1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            dv_ff[k + 1] <= nxt;
         end
      end
   end

   // result assembly
   logic                 qs_re, qs_im;
   logic signed [DW-1:0] qv_re, qv_im;
   logic signed [DW-1:0] o_re, o_im;

   always_comb begin
      qs_re = dv_ff[NSTG].ov_re || (dv_ff[NSTG].q_re[DW-1] &&
              (!dv_ff[NSTG].neg_re || (dv_ff[NSTG].q_re[DW-2:0] != '0)));
      qs_im = dv_ff[NSTG].ov_im || (dv_ff[NSTG].q_im[DW-1] &&
              (!dv_ff[NSTG].neg_im || (dv_ff[NSTG].q_im[DW-2:0] != '0)));
      qv_re = dv_ff[NSTG].neg_re ? $signed(-dv_ff[NSTG].q_re) : $signed(dv_ff[NSTG].q_re);
      qv_im = dv_ff[NSTG].neg_im ? $signed(-dv_ff[NSTG].q_im) : $signed(dv_ff[NSTG].q_im);
      if (qs_re) begin
         qv_re = dv_ff[NSTG].neg_re ? MIND : MAXD;
      end
      if (qs_im) begin
         qv_im = dv_ff[NSTG].neg_im ? MIND : MAXD;
      end
      o_re       = dv_ff[NSTG].fv_re[DW-1:0];
      o_im       = dv_ff[NSTG].fv_im[DW-1:0];
      fin.status = dv_ff[NSTG].fsat ? ST_SAT : ST_OK;
      if (dv_ff[NSTG].func == FUNC_DIV) begin
         if (dv_ff[NSTG].dz) begin
            o_re       = '0;
            o_im       = '0;
            fin.status = ST_DZ;
         end else begin
            o_re       = qv_re;
            o_im       = qv_im;
            fin.status = (qs_re || qs_im) ? ST_SAT : ST_OK;
         end
      end
      fin.res_re = PORT_W'(o_re);
      fin.res_im = PORT_W'(o_im);
   end

   // output buffer
   assign push      = ce && vld_ff[NSTG];
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= fin;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("output buffer count out of range");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_DZ) |-> (rsp_data.res_re == '0) &&
      (rsp_data.res_im == '0)) else $error("divide-by-zero item with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK) || (rsp_data.status == ST_DZ) ||
      (rsp_data.status == ST_SAT)) else $error("bad status code");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff[NSTG]) && $stable(dv_ff[NSTG]))
      else $error("pipeline moved while stalled");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) || (cnt_ff == 2'd0) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("buffer pointers disagree with count");

endmodule

/* dv/complex_arithmetic_unit_core_tb.sv */
// Testbench for the complex arithmetic unit: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb;
   import cau_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = DW + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_RANDOM = 800;

   class cau_scoreboard;
      rsp_type expected_q[$];
      int mismatches;

      function automatic logic signed [DW-1:0] saturate(logic signed [127:0] v, ref bit sat);
         logic signed [127:0] hi;
         logic signed [127:0] lo;
         hi = (128'sd1 <<< (DW - 1)) - 1;
         lo = -(128'sd1 <<< (DW - 1));
         if (v > hi) begin
            sat = 1;
            return hi[DW-1:0];
         end
         if (v < lo) begin
            sat = 1;
            return lo[DW-1:0];
         end
         return v[DW-1:0];
      endfunction

      function automatic logic signed [127:0] round_fixed(logic signed [127:0] v);
         logic signed [127:0] m;
         m = (v < 0) ? -v : v;
         m = (m + (128'sd1 <<< (FB - 1))) >>> FB;
         return (v < 0) ? -m : m;
      endfunction

      function automatic logic signed [127:0] round_quot(logic signed [127:0] n,
                                                           logic signed [127:0] d);
         logic signed [127:0] m;
         logic signed [127:0] q;
         m = ((n < 0) ? -n : n) <<< FB;
         q = ((m <<< 1) + d) / (d <<< 1);
         return (n < 0) ? -q : q;
      endfunction

      function automatic rsp_type compute(req_type r);
         rsp_type o;
         logic signed [127:0] ar, ai, br, bi, re, im, d;
         bit sat;
         ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
         sat = 0;
         o = '0;
         case (r.func)
            FUNC_ADD: begin re = ar + br; im = ai + bi; end
            FUNC_SUB: begin re = ar - br; im = ai - bi; end
            FUNC_MUL: begin
               re = round_fixed(ar * br - ai * bi);
               im = round_fixed(ar * bi + ai * br);
            end
            FUNC_DIV: begin
               d = br * br + bi * bi;
               if (d == 0) begin
                  o.status = ST_DZ;
                  return o;
               end
               re = round_quot(ar * br + ai * bi, d);
               im = round_quot(ai * br - ar * bi, d);
            end
            FUNC_CONJ: begin re = ar; im = -ai; end
            default: return o;
         endcase
         o.res_re = saturate(re, sat);
         o.res_im = saturate(im, sat);
         o.status = sat ? ST_SAT : ST_OK;
         return o;
      endfunction

      function void note_item(req_type r);
         expected_q.push_back(compute(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = expected_q.pop_front();
         if (got.res_re !== want.res_re || got.res_im !== want.res_im ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                        want.res_re, want.res_im, want.status,
                        got.res_re, got.res_im, got.status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;

   cau_scoreboard sb = new();
   bit sending_done = 0;
   bit calm = 0;
   bit holdoff_done = 0;
   int idle_cycles = 0;
   int sent = 0;

   complex_arithmetic_unit_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_item(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4, 5: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
         6: return $urandom_range(0, 32'h7f_ffff) - 32'h40_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(req_type r);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_random();
      req_type r;
      r.func = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      r.a_re = pick_value(); r.a_im = pick_value();
      r.b_re = pick_value(); r.b_im = pick_value();
      if ($urandom_range(0, 19) == 0) begin r.b_re = 0; r.b_im = 0; end
      send_item(r);
   endtask

   task automatic send_directed();
      req_type r;
      logic [31:0] ext[4];
      ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
      for (int f = 0; f < 8; f++) begin
         r.func = 3'(f);
         r.a_re = ext[f % 4]; r.a_im = ext[(f + 1) % 4];
         r.b_re = ext[(f + 2) % 4]; r.b_im = ext[(f + 3) % 4];
         send_item(r);
      end
      r = '{FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0};
      send_item(r);
      r = '{FUNC_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1};
      send_item(r);
      r = '{FUNC_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0};
      send_item(r);
      r = '{FUNC_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0};
      send_item(r);
      r = '{FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0};
      send_item(r);
      r = '{FUNC_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0};
      send_item(r);
      r = '{FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff};
      send_item(r);
      r = '{FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff};
      send_item(r);
      r = '{FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send_item(r);
      r = '{FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send_item(r);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_directed();
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i >= N_RANDOM - 150) calm = 1;
         send_random();
      end
      @(negedge clock);
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!holdoff_done && sent > 200) begin
            rsp_ready <= 0;
            repeat (150) @(negedge clock);
            holdoff_done = 1;
         end
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   initial begin
      int waited;
      wait (sending_done);
      waited = 0;
      while (sb.expected_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
